[hdl/tcdr_pkg.sv]
// Shared definitions for the text cell damage renderer: command codes,
// cache geometry, result field widths and the two 8-entry color palettes.
// No dependencies.
package tcdr_pkg;

    typedef enum logic [1:0] {
        CMD_INVALIDATE = 2'd0,
        CMD_BEGIN      = 2'd1,
        CMD_CELL       = 2'd2,
        CMD_END        = 2'd3
    } cmd_t;

    // Cache geometry: cell (col, row) lives at row * CACHE_COLS + col
    localparam int unsigned CACHE_COLS = 128;
    localparam int unsigned CACHE_ROWS = 64;

    localparam int unsigned COLOR_W = 24;
    localparam int unsigned COUNT_W = 14;

    typedef logic [COLOR_W-1:0] color_t;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_VISIBLE_COLS = 2'd0;
    localparam logic [1:0] REG_VISIBLE_ROWS = 2'd1;

    function automatic color_t pal_dim(input logic [2:0] code);
        color_t c;
        case (code)
            3'd0:    c = 24'h000000;
            3'd1:    c = 24'hAA0000;
            3'd2:    c = 24'h00AA00;
            3'd3:    c = 24'hAA5500;
            3'd4:    c = 24'h0000AA;
            3'd5:    c = 24'hAA00AA;
            3'd6:    c = 24'h00AAAA;
            default: c = 24'hAAAAAA;
        endcase
        return c;
    endfunction

    function automatic color_t pal_lit(input logic [2:0] code);
        color_t c;
        case (code)
            3'd0:    c = 24'h555555;
            3'd1:    c = 24'hFF5555;
            3'd2:    c = 24'h55FF55;
            3'd3:    c = 24'hFFFF55;
            3'd4:    c = 24'h5555FF;
            3'd5:    c = 24'hFF55FF;
            3'd6:    c = 24'h55FFFF;
            default: c = 24'hFFFFFF;
        endcase
        return c;
    endfunction

endpackage

[hdl/text_cell_damage_renderer_top.sv]
// Text cell damage renderer: cell cache memory, sweep bookkeeping and
// palette lookup in one module. Depends on tcdr_pkg.
//
// One command word is taken per clock while in_stall is low, and each gives
// exactly one result word. The cache is read and the command registered at
// acceptance; compare, write-back and output load follow when that stage moves
// on, which out_stall can hold off. The rate is set by the single read and
// single write port of the cell cache; a cell that hits the entry being written
// in the same cycle is served by forwarding. After reset the cache is cleared
// one entry per cycle, all CACHE_COLS*CACHE_ROWS entries (8192), while in_stall
// stays high; configuration writes are taken throughout. cfg_ready is always high.
module text_cell_damage_renderer_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // command channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [6:0]  cell_col,
    input  logic [5:0]  cell_row,
    input  logic [7:0]  glyph_code,
    input  logic [7:0]  cell_attr,
    input  logic        cursor_on,
    input  logic [6:0]  cursor_col,
    input  logic [5:0]  cursor_row,
    input  logic [6:0]  rows_limit,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        draw_valid,
    output logic [6:0]  draw_col,
    output logic [5:0]  draw_row,
    output logic [7:0]  draw_glyph,
    output logic [23:0] fg_color,
    output logic [23:0] bg_color,
    output logic [5:0]  sweep_first_row,
    output logic [6:0]  sweep_stop_row,
    output logic        more_pending,
    output logic [13:0] drawn_count
);

    localparam int DEPTH = int'(tcdr_pkg::CACHE_COLS * tcdr_pkg::CACHE_ROWS);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef struct packed {
        tcdr_pkg::cmd_t  cmd;
        logic [6:0]      col;
        logic [5:0]      row;
        logic [7:0]      glyph;
        logic [7:0]      attr;
        logic            show;
        logic [6:0]      ccol;
        logic [5:0]      crow;
        logic [6:0]      limit;
        logic [AW-1:0]   addr;
    } item_t;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [7:0] visible_cols_reg;
    logic [6:0] visible_rows_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visible_cols_reg <= 8'd80;
            visible_rows_reg <= 7'd25;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == tcdr_pkg::REG_VISIBLE_COLS)
                visible_cols_reg <= cfg_data;
            else if (cfg_index == tcdr_pkg::REG_VISIBLE_ROWS)
                visible_rows_reg <= cfg_data[6:0];
        end
    end

    logic [7:0] cols;
    logic [6:0] rows;

    assign cols = (9'(visible_cols_reg) < 9'(tcdr_pkg::CACHE_COLS)) ? visible_cols_reg
                                                                    : 8'(tcdr_pkg::CACHE_COLS);
    assign rows = (8'(visible_rows_reg) < 8'(tcdr_pkg::CACHE_ROWS)) ? visible_rows_reg
                                                                    : 7'(tcdr_pkg::CACHE_ROWS);

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    logic          clearing_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          s1_valid_reg;
    item_t         s1_reg;
    logic          out_valid_reg;
    logic          s1_go;
    logic          accept;

    assign s1_go    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = clearing_reg || (s1_valid_reg && !s1_go);
    assign accept   = in_valid && !in_stall;

    logic [31:0]   idx_wide;
    logic [AW-1:0] in_addr;

    assign idx_wide = 32'(cell_row) * 32'(tcdr_pkg::CACHE_COLS) + 32'(cell_col);
    assign in_addr  = idx_wide[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(DEPTH - 1))
                    clearing_reg <= 1'b0;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (s1_go)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.cmd   <= tcdr_pkg::cmd_t'(command);
            s1_reg.col   <= cell_col;
            s1_reg.row   <= cell_row;
            s1_reg.glyph <= glyph_code;
            s1_reg.attr  <= cell_attr;
            s1_reg.show  <= cursor_on;
            s1_reg.ccol  <= cursor_col;
            s1_reg.crow  <= cursor_row;
            s1_reg.limit <= rows_limit;
            s1_reg.addr  <= in_addr;
        end
    end

    // ------------------------------------------------------------------
    // Cell cache: one read port, one write port, registered read data
    // ------------------------------------------------------------------
    logic [15:0]   cell_cache [DEPTH];
    logic [15:0]   rd_data_reg;
    logic          fwd_reg;
    logic [15:0]   fwd_data_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          cell_wr;

    assign wr_en   = clearing_reg || cell_wr;
    assign wr_addr = clearing_reg ? clr_addr_reg : s1_reg.addr;
    assign wr_data = clearing_reg ? 16'h0000 : {s1_reg.attr, s1_reg.glyph};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            cell_cache[wr_addr] <= wr_data;
        if (accept)
            rd_data_reg <= cell_cache[in_addr];
    end

    // Catch the write that lands on the entry being read at the same edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_reg <= 1'b0;
        else if (accept)
            fwd_reg <= cell_wr && (s1_reg.addr == in_addr);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            fwd_data_reg <= wr_data;
    end

    // ------------------------------------------------------------------
    // Sweep state
    // ------------------------------------------------------------------
    logic         cache_valid_reg,  cache_valid_next;
    logic [7:0]   cached_cols_reg,  cached_cols_next;
    logic [6:0]   cached_rows_reg,  cached_rows_next;
    logic [6:0]   cached_ccol_reg,  cached_ccol_next;
    logic [5:0]   cached_crow_reg,  cached_crow_next;
    logic         cached_shown_reg, cached_shown_next;
    logic [6:0]   resume_row_reg,   resume_row_next;
    logic         sweep_full_reg,   sweep_full_next;
    logic [6:0]   bound_start_reg,  bound_start_next;
    logic [6:0]   bound_stop_reg,   bound_stop_next;
    logic         cur_show_reg,     cur_show_next;
    logic [6:0]   cur_col_reg,      cur_col_next;
    logic [5:0]   cur_row_reg,      cur_row_next;
    logic [13:0]  drawn_reg,        drawn_next;

    // result word
    logic               r_draw;
    logic [6:0]         r_col;
    logic [5:0]         r_row;
    logic [7:0]         r_glyph;
    tcdr_pkg::color_t   r_fg;
    tcdr_pkg::color_t   r_bg;
    logic [5:0]         r_first;
    logic [6:0]         r_stop;
    logic               r_more;
    logic [13:0]        r_count;

    logic               mid;
    logic [6:0]         start;
    logic [7:0]         start_sum;
    logic               in_sweep;
    logic [15:0]        was;
    logic               now_cur;
    logic               was_cur;
    logic               need_draw;
    tcdr_pkg::color_t   pal_fg;
    tcdr_pkg::color_t   pal_bg;
    tcdr_pkg::color_t   rev_fg;
    tcdr_pkg::color_t   rev_bg;

    always_comb
    begin
        mid = (resume_row_reg != 7'd0) && (resume_row_reg < rows) &&
              (cached_cols_reg == cols) && (cached_rows_reg == rows);
        start     = mid ? resume_row_reg : 7'd0;
        start_sum = 8'(start) + 8'(s1_reg.limit);

        in_sweep = (8'(s1_reg.col) < cols) && ({1'b0, s1_reg.row} >= bound_start_reg) &&
                   ({1'b0, s1_reg.row} < bound_stop_reg) && ({1'b0, s1_reg.row} < rows);
        was      = fwd_reg ? fwd_data_reg : rd_data_reg;
        now_cur  = cur_show_reg && (s1_reg.col == cur_col_reg) && (s1_reg.row == cur_row_reg);
        was_cur  = !sweep_full_reg && cached_shown_reg &&
                   (s1_reg.col == cached_ccol_reg) && (s1_reg.row == cached_crow_reg);
        need_draw = in_sweep && (sweep_full_reg || (was[7:0] != s1_reg.glyph) ||
                    (was[15:8] != s1_reg.attr) || (now_cur != was_cur));

        pal_fg = s1_reg.attr[3] ? tcdr_pkg::pal_lit(s1_reg.attr[2:0])
                                : tcdr_pkg::pal_dim(s1_reg.attr[2:0]);
        pal_bg = tcdr_pkg::pal_dim(s1_reg.attr[6:4]);
        rev_fg = s1_reg.attr[7] ? pal_bg : pal_fg;
        rev_bg = s1_reg.attr[7] ? pal_fg : pal_bg;
    end

    always_comb
    begin
        cache_valid_next  = cache_valid_reg;
        cached_cols_next  = cached_cols_reg;
        cached_rows_next  = cached_rows_reg;
        cached_ccol_next  = cached_ccol_reg;
        cached_crow_next  = cached_crow_reg;
        cached_shown_next = cached_shown_reg;
        resume_row_next   = resume_row_reg;
        sweep_full_next   = sweep_full_reg;
        bound_start_next  = bound_start_reg;
        bound_stop_next   = bound_stop_reg;
        cur_show_next     = cur_show_reg;
        cur_col_next      = cur_col_reg;
        cur_row_next      = cur_row_reg;
        drawn_next        = drawn_reg;
        cell_wr           = 1'b0;

        r_draw  = 1'b0;
        r_col   = '0;
        r_row   = '0;
        r_glyph = '0;
        r_fg    = '0;
        r_bg    = '0;
        r_first = '0;
        r_stop  = '0;
        r_more  = 1'b0;
        r_count = '0;

        if (s1_go)
        begin
            unique case (s1_reg.cmd)
                tcdr_pkg::CMD_INVALIDATE:
                begin
                    cache_valid_next = 1'b0;
                    resume_row_next  = 7'd0;
                end
                tcdr_pkg::CMD_BEGIN:
                begin
                    sweep_full_next = (cached_cols_reg != cols) || (cached_rows_reg != rows) ||
                                      (!cache_valid_reg && !mid);
                    bound_start_next = start;
                    if ((s1_reg.limit == 7'd0) || (start_sum >= 8'(rows)))
                        bound_stop_next = rows;
                    else
                        bound_stop_next = start_sum[6:0];
                    cur_show_next = s1_reg.show;
                    cur_col_next  = s1_reg.ccol;
                    cur_row_next  = s1_reg.crow;
                    drawn_next    = '0;
                    r_first       = start[5:0];
                    r_stop        = bound_stop_next;
                end
                tcdr_pkg::CMD_CELL:
                begin
                    if (need_draw)
                    begin
                        cell_wr = 1'b1;
                        if (drawn_reg != '1)
                            drawn_next = drawn_reg + 14'd1;
                        r_draw  = 1'b1;
                        r_col   = s1_reg.col;
                        r_row   = s1_reg.row;
                        r_glyph = s1_reg.glyph;
                        r_fg    = now_cur ? rev_bg : rev_fg;
                        r_bg    = now_cur ? rev_fg : rev_bg;
                    end
                end
                tcdr_pkg::CMD_END:
                begin
                    cached_cols_next = cols;
                    cached_rows_next = rows;
                    if (bound_stop_reg >= rows)
                    begin
                        cache_valid_next  = 1'b1;
                        cached_ccol_next  = cur_col_reg;
                        cached_crow_next  = cur_row_reg;
                        cached_shown_next = cur_show_reg;
                        resume_row_next   = 7'd0;
                    end
                    else
                    begin
                        resume_row_next = bound_stop_reg;
                        r_more          = 1'b1;
                    end
                    r_count = drawn_reg;
                    // collapse the sweep so stray cells are dropped
                    bound_start_next = bound_stop_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_valid_reg  <= 1'b0;
            cached_cols_reg  <= '0;
            cached_rows_reg  <= '0;
            cached_ccol_reg  <= '0;
            cached_crow_reg  <= '0;
            cached_shown_reg <= 1'b0;
            resume_row_reg   <= '0;
            sweep_full_reg   <= 1'b0;
            bound_start_reg  <= '0;
            bound_stop_reg   <= '0;
            cur_show_reg     <= 1'b0;
            cur_col_reg      <= '0;
            cur_row_reg      <= '0;
            drawn_reg        <= '0;
        end
        else
        begin
            cache_valid_reg  <= cache_valid_next;
            cached_cols_reg  <= cached_cols_next;
            cached_rows_reg  <= cached_rows_next;
            cached_ccol_reg  <= cached_ccol_next;
            cached_crow_reg  <= cached_crow_next;
            cached_shown_reg <= cached_shown_next;
            resume_row_reg   <= resume_row_next;
            sweep_full_reg   <= sweep_full_next;
            bound_start_reg  <= bound_start_next;
            bound_stop_reg   <= bound_stop_next;
            cur_show_reg     <= cur_show_next;
            cur_col_reg      <= cur_col_next;
            cur_row_reg      <= cur_row_next;
            drawn_reg        <= drawn_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_go)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            draw_valid      <= r_draw;
            draw_col        <= r_col;
            draw_row        <= r_row;
            draw_glyph      <= r_glyph;
            fg_color        <= r_fg;
            bg_color        <= r_bg;
            sweep_first_row <= r_first;
            sweep_stop_row  <= r_stop;
            more_pending    <= r_more;
            drawn_count     <= r_count;
        end
    end

    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s1_valid_reg)
        else $error("item in flight during cache clear");

    a_forward_matches_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && fwd_reg) |-> (s1_reg.addr == $past(wr_addr)))
        else $error("forwarded data from a different cache entry");

    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_go))
        else $error("result word appeared without a processed command");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && (s1_reg.cmd != tcdr_pkg::CMD_BEGIN)) |=>
        (drawn_reg >= $past(drawn_reg)))
        else $error("drawn counter went backwards inside a sweep");

    a_stop_within_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && (s1_reg.cmd == tcdr_pkg::CMD_BEGIN) && !(cfg_valid && cfg_ready)) |=>
        (bound_stop_reg <= rows))
        else $error("sweep stop row beyond visible rows");

endmodule
